FILE: sv/qn_pkg.sv
`default_nettype none
package qn_pkg;

   localparam int DEF_MAX_GROUPS = 16;
   localparam int DEF_MAX_VALUES = 1024;
   localparam int DEF_VALUE_BITS = 32;

   localparam int CMD_BITS     = 2;
   localparam int TAG_BITS     = 4;
   localparam int IN_VAL_BITS  = 32;
   localparam int STATUS_BITS  = 2;
   localparam int GC_REG_BITS  = 5;
   localparam int ACT_BITS     = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_GROUP_COUNT = 3'd0;
   localparam logic [GC_REG_BITS-1:0] GROUP_COUNT_RESET = 5'd1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD = 2'd0,
      CMD_NORM = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   typedef enum logic {
      OP_INTERP = 1'b0,
      OP_AVG    = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      IP_IDLE,
      IP_POS_GO,
      IP_POS_WAIT,
      IP_LO_RD,
      IP_LO_LAT,
      IP_HI_RD,
      IP_HI_LAT,
      IP_FRAC_MUL,
      IP_FRAC_GO,
      IP_FRAC_WAIT,
      IP_END_RD,
      IP_END_LAT,
      IP_AVG_GO,
      IP_AVG_WAIT,
      IP_DONE
   } ip_state_type;

   typedef enum logic [3:0] {
      N_IDLE,
      N_SCAN,
      N_RK_RD,
      N_RK_LAT,
      N_RK_SCAN,
      N_RK_WR,
      N_REF_G,
      N_REF_WAIT,
      N_AVG,
      N_AVG_WAIT,
      N_WB_RD,
      N_WB_LAT,
      N_WB_GO,
      N_WB_WAIT
   } norm_state_type;

endpackage
`default_nettype wire

FILE: sv/qn_ram.sv
`default_nettype none
module qn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: sv/qn_div.sv
`default_nettype none
module qn_div #(
   parameter int DVD_W = 40,
   parameter int DVS_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient,
   output logic      [DVS_W-1:0] remainder
);
   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] q_ff, q_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_sub;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         // One quotient bit per cycle, restoring form.
         q_in   = {q_ff[DVD_W-2:0], ge};
         rem_in = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

FILE: sv/qn_interp.sv
`default_nettype none
module qn_interp #(
   parameter int VB    = 32,
   parameter int CNT_W = 11,
   parameter int IDX_W = 10,
   parameter int SUM_W = 37,
   parameter int DVS_W = 11,
   parameter int DVD_W = 43
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire qn_pkg::op_type   op,
   input  wire logic [CNT_W-1:0] m,
   input  wire logic [CNT_W-1:0] n,
   input  wire logic [CNT_W-1:0] k,
   input  wire logic [SUM_W-1:0] sum,
   input  wire logic [DVS_W-1:0] nonempty,
   input  wire logic [VB-1:0]    arr_rdata,
   output logic      [IDX_W-1:0] rd_idx,
   output logic                  done,
   output logic      [VB-1:0]    result
);
   import qn_pkg::*;

   ip_state_type     st_ff, st_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [DVS_W-1:0] r_ff, r_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [VB-1:0]    lo_ff, lo_in;
   logic [VB-1:0]    diff_ff, diff_in;
   logic [VB-1:0]    res_ff, res_in;
   logic             div_start, div_done;
   logic [DVD_W-1:0] div_q;
   logic [DVS_W-1:0] div_r;
   logic [2*CNT_W-1:0] pos_prod;
   logic [VB+DVS_W-1:0] frac_prod;
   logic [CNT_W:0]   k_next;

   qn_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd_ff),
      .divisor   (dvs_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IP_IDLE;
      end else begin
         st_ff <= st_in;
      end
      idx_ff  <= idx_in;
      r_ff    <= r_in;
      dvs_ff  <= dvs_in;
      dvd_ff  <= dvd_in;
      lo_ff   <= lo_in;
      diff_ff <= diff_in;
      res_ff  <= res_in;
   end

   always_comb begin
      st_in     = st_ff;
      idx_in    = idx_ff;
      r_in      = r_ff;
      dvs_in    = dvs_ff;
      dvd_in    = dvd_ff;
      lo_in     = lo_ff;
      diff_in   = diff_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      pos_prod  = k * (m - 1'b1);
      frac_prod = diff_ff * r_ff;
      k_next    = {1'b0, k} + 1'b1;
      case (st_ff)
         IP_IDLE: begin
            if (start) begin
               if (op == OP_AVG) begin
                  dvd_in = DVD_W'(sum);
                  dvs_in = nonempty;
                  st_in  = IP_AVG_GO;
               end else if (k_next >= {1'b0, n}) begin
                  idx_in = IDX_W'(m - 1'b1);
                  st_in  = IP_END_RD;
               end else if (k == '0) begin
                  idx_in = '0;
                  st_in  = IP_END_RD;
               end else begin
                  dvd_in = DVD_W'(pos_prod);
                  dvs_in = DVS_W'(n - 1'b1);
                  st_in  = IP_POS_GO;
               end
            end
         end
         IP_POS_GO: begin
            div_start = 1'b1;
            st_in     = IP_POS_WAIT;
         end
         IP_POS_WAIT: begin
            if (div_done) begin
               idx_in = IDX_W'(div_q);
               r_in   = div_r;
               st_in  = IP_LO_RD;
            end
         end
         IP_LO_RD: st_in = IP_LO_LAT;
         IP_LO_LAT: begin
            lo_in = arr_rdata;
            if (r_ff == '0) begin
               res_in = arr_rdata;
               st_in  = IP_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = IP_HI_RD;
            end
         end
         IP_HI_RD: st_in = IP_HI_LAT;
         IP_HI_LAT: begin
            if (arr_rdata < lo_ff) begin
               res_in = lo_ff;
               st_in  = IP_DONE;
            end else begin
               diff_in = arr_rdata - lo_ff;
               st_in   = IP_FRAC_MUL;
            end
         end
         IP_FRAC_MUL: begin
            dvd_in = DVD_W'(frac_prod);
            st_in  = IP_FRAC_GO;
         end
         IP_FRAC_GO: begin
            div_start = 1'b1;
            st_in     = IP_FRAC_WAIT;
         end
         IP_FRAC_WAIT: begin
            if (div_done) begin
               res_in = lo_ff + VB'(div_q);
               st_in  = IP_DONE;
            end
         end
         IP_END_RD: st_in = IP_END_LAT;
         IP_END_LAT: begin
            res_in = arr_rdata;
            st_in  = IP_DONE;
         end
         IP_AVG_GO: begin
            div_start = 1'b1;
            st_in     = IP_AVG_WAIT;
         end
         IP_AVG_WAIT: begin
            if (div_done) begin
               res_in = VB'(div_q);
               st_in  = IP_DONE;
            end
         end
         IP_DONE: st_in = IP_IDLE;
         default: st_in = IP_IDLE;
      endcase
   end

   assign rd_idx = idx_ff;
   assign done   = (st_ff == IP_DONE);
   assign result = res_ff;
endmodule
`default_nettype wire

FILE: sv/quantile_normalizer_core.sv
// Loads and reads are taken one per cycle while busy is low; a read word appears in the cycle
// after it is taken, and the receiver cannot stall it. Normalize holds busy while it runs; with
// many values in few groups its run is dominated by the pairwise rank scan through the value
// memory's single read port. Reset clears counts, group sizes, the read pointer, the drop flag
// and sets group_count to one; the value, rank, sorted and reference memories are not cleared.
`default_nettype none
module quantile_normalizer_core #(
   parameter int MAX_GROUPS = qn_pkg::DEF_MAX_GROUPS,
   parameter int MAX_VALUES = qn_pkg::DEF_MAX_VALUES,
   parameter int VALUE_BITS = qn_pkg::DEF_VALUE_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [qn_pkg::CMD_BITS-1:0]    req_command,
   input  wire logic [qn_pkg::TAG_BITS-1:0]    req_group_tag,
   input  wire logic [qn_pkg::IN_VAL_BITS-1:0] req_intensity,
   output logic                                rsp_strobe,
   output logic      [qn_pkg::TAG_BITS-1:0]    rsp_group_of_value,
   output logic      [qn_pkg::IN_VAL_BITS-1:0] rsp_normalized_value,
   output logic                                rsp_is_last,
   output logic      [qn_pkg::STATUS_BITS-1:0] rsp_status,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [qn_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [qn_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [qn_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                pready
);
   import qn_pkg::*;

   localparam int VB    = VALUE_BITS;
   localparam int IDX_W = $clog2(MAX_VALUES);
   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam int GI_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GC_W  = $clog2(MAX_GROUPS + 1);
   localparam int SUM_W = VB + GC_W;
   localparam int DVS_W = (CNT_W > GC_W) ? CNT_W : GC_W;
   localparam int DVD_W = (2 * CNT_W > VB + DVS_W) ? 2 * CNT_W : VB + DVS_W;
   localparam int VT_W  = VB + TAG_BITS;

   // Control state
   norm_state_type          st_ff, st_in;
   logic [GC_REG_BITS-1:0]  gc_ff, gc_in;
   logic [CNT_W-1:0]        lc_ff, lc_in;
   logic [CNT_W-1:0]        rp_ff, rp_in;
   logic                    drop_ff, drop_in;
   logic [CNT_W-1:0]        size_ff [MAX_GROUPS];
   logic                    size_we;
   logic [CNT_W-1:0]        gbase_ff [MAX_GROUPS];
   logic                    gbase_we;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_past_ff, rsp_past_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_drop_ff, rsp_drop_in;

   // Normalize working registers
   logic [GC_W-1:0]         g_ff, g_in;
   logic [CNT_W-1:0]        base_ff, base_in;
   logic [CNT_W-1:0]        largest_ff, largest_in;
   logic [GC_W-1:0]         nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [CNT_W-1:0]        jd_ff, jd_in;
   logic                    pv_ff, pv_in;
   logic [IDX_W-1:0]        rank_ff, rank_in;
   logic [VB-1:0]           vi_ff, vi_in;
   logic [TAG_BITS-1:0]     ti_ff, ti_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;

   // Memory ports
   logic                    vt_we;
   logic [IDX_W-1:0]        vt_waddr, vt_raddr;
   logic [VT_W-1:0]         vt_wdata, vt_rdata;
   logic                    rk_we;
   logic [IDX_W-1:0]        rk_rdata;
   logic                    so_we;
   logic [IDX_W-1:0]        so_waddr, so_raddr;
   logic [VB-1:0]           so_rdata;
   logic                    rf_we;
   logic [VB-1:0]           rf_rdata;

   // Interpolation unit
   logic                    ip_start, ip_done;
   op_type                  ip_op;
   logic [CNT_W-1:0]        ip_m, ip_n, ip_k;
   logic [IDX_W-1:0]        ip_idx;
   logic [VB-1:0]           ip_arr, ip_res;

   logic [GI_W-1:0]         sel_g;
   logic [CNT_W-1:0]        size_sel, gbase_sel;
   logic [ACT_BITS-1:0]     act;
   logic                    accept, cfg_wr, match;
   logic [VB-1:0]           vr;
   logic [TAG_BITS-1:0]     tr;

   assign accept = start && !busy;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_GROUP_COUNT) ? CSR_DATA_W'(gc_ff) : '0;
   assign busy   = (st_ff != N_IDLE);

   qn_ram #(.WIDTH(VT_W), .DEPTH(MAX_VALUES)) u_vt_ram (
      .clock (clock), .we (vt_we), .waddr (vt_waddr), .wdata (vt_wdata),
      .raddr (vt_raddr), .rdata (vt_rdata)
   );
   qn_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VALUES)) u_rank_ram (
      .clock (clock), .we (rk_we), .waddr (i_ff[IDX_W-1:0]), .wdata (rank_ff),
      .raddr (i_ff[IDX_W-1:0]), .rdata (rk_rdata)
   );
   qn_ram #(.WIDTH(VB), .DEPTH(MAX_VALUES)) u_sort_ram (
      .clock (clock), .we (so_we), .waddr (so_waddr), .wdata (vi_ff),
      .raddr (so_raddr), .rdata (so_rdata)
   );
   qn_ram #(.WIDTH(VB), .DEPTH(MAX_VALUES)) u_ref_ram (
      .clock (clock), .we (rf_we), .waddr (j_ff[IDX_W-1:0]), .wdata (ip_res),
      .raddr (ip_idx), .rdata (rf_rdata)
   );

   qn_interp #(
      .VB (VB), .CNT_W (CNT_W), .IDX_W (IDX_W), .SUM_W (SUM_W),
      .DVS_W (DVS_W), .DVD_W (DVD_W)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .start     (ip_start),
      .op        (ip_op),
      .m         (ip_m),
      .n         (ip_n),
      .k         (ip_k),
      .sum       (sum_ff),
      .nonempty  (DVS_W'(nonempty_ff)),
      .arr_rdata (ip_arr),
      .rd_idx    (ip_idx),
      .done      (ip_done),
      .result    (ip_res)
   );

   always_comb begin
      case (st_ff)
         N_IDLE:                   sel_g = GI_W'(req_group_tag);
         N_RK_WR, N_WB_GO, N_WB_WAIT: sel_g = GI_W'(ti_ff);
         default:                  sel_g = GI_W'(g_ff);
      endcase
      size_sel  = size_ff[sel_g];
      gbase_sel = gbase_ff[sel_g];
      if (gc_ff == '0) begin
         act = ACT_BITS'(1);
      end else if (ACT_BITS'(gc_ff) > ACT_BITS'(MAX_GROUPS)) begin
         act = ACT_BITS'(MAX_GROUPS);
      end else begin
         act = ACT_BITS'(gc_ff);
      end
      so_raddr = IDX_W'(gbase_sel + CNT_W'(ip_idx));
      so_waddr = IDX_W'(gbase_sel + CNT_W'(rank_ff));
      ip_arr   = (st_ff == N_REF_WAIT) ? so_rdata : rf_rdata;
      vr       = vt_rdata[VB-1:0];
      tr       = vt_rdata[VB +: TAG_BITS];
      match    = pv_ff && (tr == ti_ff) && (jd_ff != i_ff) &&
                 ((vr < vi_ff) || ((vr == vi_ff) && (jd_ff < i_ff)));
   end

   always_comb begin
      st_in        = st_ff;
      gc_in        = gc_ff;
      lc_in        = lc_ff;
      rp_in        = rp_ff;
      drop_in      = drop_ff;
      size_we      = 1'b0;
      gbase_we     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_past_in  = rsp_past_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      g_in         = g_ff;
      base_in      = base_ff;
      largest_in   = largest_ff;
      nonempty_in  = nonempty_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = jd_ff;
      pv_in        = pv_ff;
      rank_in      = rank_ff;
      vi_in        = vi_ff;
      ti_in        = ti_ff;
      sum_in       = sum_ff;
      vt_we        = 1'b0;
      vt_waddr     = i_ff[IDX_W-1:0];
      vt_wdata     = {ti_ff, ip_res};
      vt_raddr     = rp_ff[IDX_W-1:0];
      rk_we        = 1'b0;
      so_we        = 1'b0;
      rf_we        = 1'b0;
      ip_start     = 1'b0;
      ip_op        = OP_INTERP;
      ip_m         = size_sel;
      ip_n         = largest_ff;
      ip_k         = j_ff;

      if (cfg_wr && paddr == CSR_GROUP_COUNT) begin
         gc_in = pwdata[GC_REG_BITS-1:0];
      end

      case (st_ff)
         N_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_LOAD: begin
                     if ((ACT_BITS'(req_group_tag) >= act) ||
                         (lc_ff >= CNT_W'(MAX_VALUES))) begin
                        drop_in = 1'b1;
                     end else begin
                        vt_we    = 1'b1;
                        vt_waddr = lc_ff[IDX_W-1:0];
                        vt_wdata = {req_group_tag, VB'(req_intensity)};
                        size_we  = 1'b1;
                        lc_in    = lc_ff + 1'b1;
                     end
                  end
                  CMD_NORM: begin
                     rp_in       = '0;
                     g_in        = '0;
                     base_in     = '0;
                     largest_in  = '0;
                     nonempty_in = '0;
                     st_in       = N_SCAN;
                  end
                  CMD_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_past_in  = (rp_ff >= lc_ff);
                     rsp_last_in  = (rp_ff + 1'b1 == lc_ff);
                     rsp_drop_in  = drop_ff;
                     if (rp_ff < lc_ff) begin
                        rp_in = rp_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         N_SCAN: begin
            // Group offsets into the sorted memory, largest size, non-empty count.
            if (g_ff == GC_W'(MAX_GROUPS)) begin
               i_in  = '0;
               st_in = (largest_ff == '0) ? N_IDLE : N_RK_RD;
            end else begin
               gbase_we = 1'b1;
               base_in  = base_ff + size_sel;
               if (size_sel > largest_ff) begin
                  largest_in = size_sel;
               end
               if (size_sel != '0) begin
                  nonempty_in = nonempty_ff + 1'b1;
               end
               g_in = g_ff + 1'b1;
            end
         end
         N_RK_RD: begin
            vt_raddr = i_ff[IDX_W-1:0];
            st_in    = N_RK_LAT;
         end
         N_RK_LAT: begin
            vi_in   = vr;
            ti_in   = tr;
            j_in    = '0;
            pv_in   = 1'b0;
            rank_in = '0;
            st_in   = N_RK_SCAN;
         end
         N_RK_SCAN: begin
            // Reads run one ahead of the compare of the previous word.
            vt_raddr = j_ff[IDX_W-1:0];
            if (match) begin
               rank_in = rank_ff + 1'b1;
            end
            if (j_ff < lc_ff) begin
               j_in  = j_ff + 1'b1;
               jd_in = j_ff;
               pv_in = 1'b1;
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  st_in = N_RK_WR;
               end
            end
         end
         N_RK_WR: begin
            rk_we = 1'b1;
            so_we = 1'b1;
            i_in  = i_ff + 1'b1;
            if (i_ff + 1'b1 == lc_ff) begin
               j_in   = '0;
               g_in   = '0;
               sum_in = '0;
               st_in  = N_REF_G;
            end else begin
               st_in = N_RK_RD;
            end
         end
         N_REF_G: begin
            if (g_ff == GC_W'(MAX_GROUPS)) begin
               st_in = N_AVG;
            end else if (size_sel == '0) begin
               g_in = g_ff + 1'b1;
            end else begin
               ip_start = 1'b1;
               st_in    = N_REF_WAIT;
            end
         end
         N_REF_WAIT: begin
            if (ip_done) begin
               sum_in = sum_ff + SUM_W'(ip_res);
               g_in   = g_ff + 1'b1;
               st_in  = N_REF_G;
            end
         end
         N_AVG: begin
            ip_start = 1'b1;
            ip_op    = OP_AVG;
            st_in    = N_AVG_WAIT;
         end
         N_AVG_WAIT: begin
            if (ip_done) begin
               rf_we = 1'b1;
               j_in  = j_ff + 1'b1;
               if (j_ff + 1'b1 == largest_ff) begin
                  i_in  = '0;
                  st_in = N_WB_RD;
               end else begin
                  g_in   = '0;
                  sum_in = '0;
                  st_in  = N_REF_G;
               end
            end
         end
         N_WB_RD: begin
            vt_raddr = i_ff[IDX_W-1:0];
            st_in    = N_WB_LAT;
         end
         N_WB_LAT: begin
            ti_in   = tr;
            rank_in = rk_rdata;
            st_in   = N_WB_GO;
         end
         N_WB_GO: begin
            ip_start = 1'b1;
            ip_m     = largest_ff;
            ip_n     = size_sel;
            ip_k     = CNT_W'(rank_ff);
            st_in    = N_WB_WAIT;
         end
         N_WB_WAIT: begin
            if (ip_done) begin
               vt_we = 1'b1;
               i_in  = i_ff + 1'b1;
               st_in = (i_ff + 1'b1 == lc_ff) ? N_IDLE : N_WB_RD;
            end
         end
         default: st_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= N_IDLE;
         gc_ff        <= GROUP_COUNT_RESET;
         lc_ff        <= '0;
         rp_ff        <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < MAX_GROUPS; g++) begin
            size_ff[g] <= '0;
         end
      end else begin
         st_ff        <= st_in;
         gc_ff        <= gc_in;
         lc_ff        <= lc_in;
         rp_ff        <= rp_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (size_we) begin
            size_ff[sel_g] <= size_sel + 1'b1;
         end
      end
      if (gbase_we) begin
         gbase_ff[sel_g] <= base_ff;
      end
      rsp_past_ff <= rsp_past_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
      g_ff        <= g_in;
      base_ff     <= base_in;
      largest_ff  <= largest_in;
      nonempty_ff <= nonempty_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      jd_ff       <= jd_in;
      pv_ff       <= pv_in;
      rank_ff     <= rank_in;
      vi_ff       <= vi_in;
      ti_ff       <= ti_in;
      sum_ff      <= sum_in;
   end

   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_group_of_value   = rsp_past_ff ? '0 : tr;
   assign rsp_normalized_value = rsp_past_ff ? '0 : IN_VAL_BITS'(vr);
   assign rsp_is_last          = rsp_past_ff ? 1'b0 : rsp_last_ff;
   assign rsp_status           = rsp_past_ff ? ST_EMPTY :
                                 (rsp_drop_ff ? ST_DROPPED : ST_OK);

   a_strobe_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && req_command == CMD_READ))
      else $error("result word without a taken read");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(st_ff == N_IDLE))
      else $error("result word during normalize");

   a_norm_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_NORM) |=> busy)
      else $error("normalize did not start");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      lc_ff <= CNT_W'(MAX_VALUES))
      else $error("load count beyond capacity");
endmodule
`default_nettype wire
